>>> design/bgr_pkg.sv
// shared types and constants for the blocked graph reachability block
// no dependencies; imported by bgr_ctrl, bgr_datapath and the top level
package bgr_pkg;

    // width of a node index field in a command word
    localparam int unsigned ID_W = 6;

    // default sizes handed to the top level
    localparam int unsigned DEF_NODE_COUNT    = 64;
    localparam int unsigned DEF_EDGE_CAPACITY = 256;

    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_ADD_EDGE  = 2'd1,
        OP_SET_FLAGS = 2'd2,
        OP_QUERY     = 2'd3
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] from_node;
        logic [ID_W-1:0] to_node;
        logic            node_exists;
        logic            is_source;
        logic            is_target;
        logic            is_blocked;
    } cmd_word_t;

    typedef struct packed {
        logic reachable;
        logic edges_dropped;
    } rsp_word_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic seed_step;
        logic pop;
        logic fetch;
        logic edge_step;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic trivial;
        logic seed_hit;
        logic seed_last;
        logic queue_empty;
        logic edge_hit;
        logic edge_done;
        logic out_free;
    } dp_sts_t;

endpackage

>>> design/bgr_ram.sv
// generic single write port, single read port ram with registered read
// depends on nothing
module bgr_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/bgr_ctrl.sv
// sequencing state machine for the reachability block
// depends on bgr_pkg; drives dp_cmd_t into bgr_datapath, reads dp_sts_t back
module bgr_ctrl import bgr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  op_t     cmd_op,
    output logic    cmd_stall,
    output dp_cmd_t ctl,
    input  dp_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_POP,
        S_FETCH,
        S_EDGE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // words are taken only between queries
    assign cmd_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.accept = 1'b1;
                    if (cmd_op == OP_QUERY)
                    begin
                        state_next = sts.trivial ? S_RESULT : S_SEED;
                    end
                end
            end
            S_SEED:
            begin
                ctl.seed_step = 1'b1;
                if (sts.seed_hit)
                begin
                    state_next = S_RESULT;
                end
                else if (sts.seed_last)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (sts.queue_empty)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    ctl.pop    = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                ctl.fetch  = 1'b1;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                ctl.edge_step = 1'b1;
                if (sts.edge_hit)
                begin
                    state_next = S_RESULT;
                end
                else if (sts.edge_done)
                begin
                    state_next = S_POP;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/bgr_datapath.sv
// graph storage, walk counters, frontier queue and result register
// depends on bgr_pkg and bgr_ram; steered by bgr_ctrl through dp_cmd_t
module bgr_datapath import bgr_pkg::*; #(
    parameter int unsigned NODE_COUNT    = DEF_NODE_COUNT,
    parameter int unsigned EDGE_CAPACITY = DEF_EDGE_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_word_t cmd_word,
    input  dp_cmd_t   ctl,
    output dp_sts_t   sts,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    // only indices a command word can name are ever stored
    localparam int unsigned NODE_SLOTS = (NODE_COUNT < (1 << ID_W)) ? NODE_COUNT : (1 << ID_W);
    localparam int unsigned SLOT_W     = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int unsigned Q_W        = $clog2(NODE_SLOTS + 1);
    localparam int unsigned EA_W       = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
    localparam int unsigned CNT_W      = $clog2(EDGE_CAPACITY + 1);
    localparam logic [ID_W:0]    SLOT_LIMIT = (ID_W + 1)'(NODE_SLOTS);
    localparam logic [CNT_W-1:0] EDGE_FULL  = CNT_W'(EDGE_CAPACITY);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NODE_SLOTS - 1);

    logic [NODE_SLOTS-1:0] exists_reg,  exists_next;
    logic [NODE_SLOTS-1:0] source_reg,  source_next;
    logic [NODE_SLOTS-1:0] target_reg,  target_next;
    logic [NODE_SLOTS-1:0] blocked_reg, blocked_next;
    logic [NODE_SLOTS-1:0] visited_reg, visited_next;
    logic [CNT_W-1:0]      edge_count_reg, edge_count_next;
    logic                  overflow_reg, overflow_next;
    logic [SLOT_W-1:0]     scan_reg, scan_next;
    logic [Q_W-1:0]        head_reg, head_next;
    logic [Q_W-1:0]        tail_reg, tail_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [CNT_W-1:0]      edge_idx_reg, edge_idx_next;
    logic                  pipe_vld_reg, pipe_vld_next;
    logic                  found_reg, found_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_word_t             rsp_word_reg, rsp_word_next;

    logic                  from_ok, to_ok;
    logic [SLOT_W-1:0]     from_idx, to_idx;
    logic                  is_add, is_query;
    logic                  edge_wr_en;
    logic                  edge_issue;
    logic [2*SLOT_W-1:0]   edge_rd_data;
    logic [SLOT_W-1:0]     edge_src, edge_dst;
    logic                  seed_cand;
    logic                  seed_push;
    logic                  edge_new, edge_usable, edge_push;
    logic                  q_wr_en;
    logic [SLOT_W-1:0]     q_wr_data;
    logic [SLOT_W-1:0]     q_rd_data;

    // command word decode
    assign from_ok  = {1'b0, cmd_word.from_node} < SLOT_LIMIT;
    assign to_ok    = {1'b0, cmd_word.to_node} < SLOT_LIMIT;
    assign from_idx = cmd_word.from_node[SLOT_W-1:0];
    assign to_idx   = cmd_word.to_node[SLOT_W-1:0];
    assign is_add   = ctl.accept && (cmd_word.op == OP_ADD_EDGE) && from_ok && to_ok;
    assign is_query = ctl.accept && (cmd_word.op == OP_QUERY);

    // edge store
    assign edge_wr_en = is_add && (edge_count_reg != EDGE_FULL);
    assign edge_issue = ctl.edge_step && (edge_idx_reg < edge_count_reg);

    bgr_ram #(
        .WIDTH (2 * SLOT_W),
        .DEPTH (EDGE_CAPACITY)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_wr_en),
        .wr_addr (edge_count_reg[EA_W-1:0]),
        .wr_data ({from_idx, to_idx}),
        .rd_en   (edge_issue),
        .rd_addr (edge_idx_reg[EA_W-1:0]),
        .rd_data (edge_rd_data)
    );

    assign edge_src = edge_rd_data[2*SLOT_W-1:SLOT_W];
    assign edge_dst = edge_rd_data[SLOT_W-1:0];

    // seeding: one node per cycle
    assign seed_cand = source_reg[scan_reg] && exists_reg[scan_reg] && !blocked_reg[scan_reg];
    assign seed_push = ctl.seed_step && seed_cand && !target_reg[scan_reg];

    // edge stage: data read last cycle
    assign edge_new    = pipe_vld_reg && (edge_src == cur_reg) && !visited_reg[edge_dst];
    assign edge_usable = exists_reg[edge_dst] && !blocked_reg[edge_dst];
    assign edge_push   = ctl.edge_step && edge_new && edge_usable && !target_reg[edge_dst];

    // frontier queue
    assign q_wr_en   = seed_push || edge_push;
    assign q_wr_data = seed_push ? scan_reg : edge_dst;

    bgr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NODE_SLOTS)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (tail_reg[SLOT_W-1:0]),
        .wr_data (q_wr_data),
        .rd_en   (ctl.pop),
        .rd_addr (head_reg[SLOT_W-1:0]),
        .rd_data (q_rd_data)
    );

    // status toward the controller
    always_comb
    begin
        sts.trivial     = !(|source_reg) || !(|target_reg);
        sts.seed_hit    = seed_cand && target_reg[scan_reg];
        sts.seed_last   = (scan_reg == SLOT_LAST);
        sts.queue_empty = (head_reg == tail_reg);
        sts.edge_hit    = edge_new && edge_usable && target_reg[edge_dst];
        sts.edge_done   = !(edge_idx_reg < edge_count_reg) && !pipe_vld_reg;
        sts.out_free    = !rsp_valid_reg || !rsp_stall;
    end

    // next state of graph, walk and result registers
    always_comb
    begin
        exists_next     = exists_reg;
        source_next     = source_reg;
        target_next     = target_reg;
        blocked_next    = blocked_reg;
        visited_next    = visited_reg;
        edge_count_next = edge_count_reg;
        overflow_next   = overflow_reg;
        scan_next       = scan_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        edge_idx_next   = edge_idx_reg;
        pipe_vld_next   = pipe_vld_reg;
        found_next      = found_reg;
        rsp_word_next   = rsp_word_reg;

        // graph loading
        if (ctl.accept && (cmd_word.op == OP_CLEAR))
        begin
            exists_next     = '0;
            source_next     = '0;
            target_next     = '0;
            blocked_next    = '0;
            edge_count_next = '0;
            overflow_next   = 1'b0;
        end
        if (is_add)
        begin
            if (edge_wr_en)
            begin
                edge_count_next = edge_count_reg + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
        if (ctl.accept && (cmd_word.op == OP_SET_FLAGS) && from_ok)
        begin
            exists_next[from_idx]  = cmd_word.node_exists;
            source_next[from_idx]  = cmd_word.is_source;
            target_next[from_idx]  = cmd_word.is_target;
            blocked_next[from_idx] = cmd_word.is_blocked;
        end

        // query start
        if (is_query)
        begin
            visited_next = '0;
            scan_next    = '0;
            head_next    = '0;
            tail_next    = '0;
            found_next   = sts.trivial;
        end

        // seeding
        if (ctl.seed_step)
        begin
            scan_next = scan_reg + 1'b1;
            if (sts.seed_hit)
            begin
                found_next = 1'b1;
            end
            if (seed_push)
            begin
                visited_next[scan_reg] = 1'b1;
            end
        end

        // dequeue and start an edge sweep
        if (ctl.pop)
        begin
            head_next = head_reg + 1'b1;
        end
        if (ctl.fetch)
        begin
            cur_next      = q_rd_data;
            edge_idx_next = '0;
            pipe_vld_next = 1'b0;
        end

        // edge sweep
        if (ctl.edge_step)
        begin
            pipe_vld_next = edge_issue;
            if (edge_issue)
            begin
                edge_idx_next = edge_idx_reg + 1'b1;
            end
            if (edge_new)
            begin
                visited_next[edge_dst] = 1'b1;
            end
            if (sts.edge_hit)
            begin
                found_next = 1'b1;
            end
        end

        if (q_wr_en)
        begin
            tail_next = tail_reg + 1'b1;
        end

        // result register
        rsp_valid_next = ctl.load_out || (rsp_valid_reg && rsp_stall);
        if (ctl.load_out)
        begin
            rsp_word_next.reachable     = found_reg;
            rsp_word_next.edges_dropped = overflow_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exists_reg     <= '0;
            source_reg     <= '0;
            target_reg     <= '0;
            blocked_reg    <= '0;
            visited_reg    <= '0;
            edge_count_reg <= '0;
            overflow_reg   <= 1'b0;
            scan_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            edge_idx_reg   <= '0;
            pipe_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            exists_reg     <= exists_next;
            source_reg     <= source_next;
            target_reg     <= target_next;
            blocked_reg    <= blocked_next;
            visited_reg    <= visited_next;
            edge_count_reg <= edge_count_next;
            overflow_reg   <= overflow_next;
            scan_reg       <= scan_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            edge_idx_reg   <= edge_idx_next;
            pipe_vld_reg   <= pipe_vld_next;
            found_reg      <= found_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

>>> design/blocked_graph_reachability.sv
// Blocked graph reachability: holds a directed graph and answers reachability queries.
// Command channel (cmd_valid / cmd_stall / cmd_word) carries clear, add edge, set node
// flags and query words; response channel (rsp_valid / rsp_stall / rsp_word) carries
// one word per query with reachable and edges_dropped.
// Clear, add edge and set flags words give no response and never stall the command channel.
// A query holds cmd_stall high until it finishes. Without any source or any target
// flag it goes straight to the result. Otherwise it seeds the frontier by scanning the
// N = min(NODE_COUNT, 64) node slots one per cycle, then for each dequeued node
// sweeps the whole edge store one edge per cycle through the edge ram read port;
// the walk ends early when a target is met.
// The response sits in an output register; a stalled receiver holds it there and
// load words keep being taken meanwhile; a following query waits only at its end.
// Reset (rst_n, asynchronous, active low) empties the graph, the flags and the
// overflow mark; the edge store needs no clearing pass.
// Depends on bgr_pkg, bgr_ctrl, bgr_datapath and bgr_ram.
module blocked_graph_reachability import bgr_pkg::*; #(
    parameter int unsigned NODE_COUNT    = DEF_NODE_COUNT,
    parameter int unsigned EDGE_CAPACITY = DEF_EDGE_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    dp_cmd_t ctl;
    dp_sts_t sts;

    // sequencer
    bgr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_op    (cmd_word.op),
        .cmd_stall (cmd_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    // storage and walk datapath
    bgr_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .EDGE_CAPACITY (EDGE_CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule
